// ===== sv/rtf_pkg.sv =====
// Shared types and constants for the rotozoom texel fetch core.
package rtf_pkg;

    // Texture geometry
    localparam int GRID_SIZE   = 32;
    localparam int SLICE_COUNT = 32;
    localparam int GRID_BITS   = $clog2(GRID_SIZE);
    localparam int SLICE_BITS  = $clog2(SLICE_COUNT);
    localparam int MEM_DEPTH   = GRID_SIZE * GRID_SIZE * SLICE_COUNT;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int TEXEL_W     = 8;

    // Coordinate formats: x is 5.12, y keeps bits 7..16 (5.5)
    localparam int X_FRAC_BITS = 12;
    localparam int COORD_W     = 17;
    localparam int Y_DROP_BITS = 7;
    localparam int PY_W        = COORD_W - Y_DROP_BITS;
    localparam int ROW_LSB     = X_FRAC_BITS - Y_DROP_BITS;

    // Stream word layout
    localparam int REQ_W       = 2;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 8;

    // Configuration port
    localparam int CFG_IDX_W   = 2;

    // Op queue
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_FRAME = 2'd1,
        REQ_LINE  = 2'd2,
        REQ_PIXEL = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_X   = 2'd0,
        REG_STEP_Y   = 2'd1,
        REG_ORIGIN_X = 2'd2,
        REG_ORIGIN_Y = 2'd3
    } cfg_reg_t;

    // One texel store access
    typedef struct packed {
        logic               rd;
        logic [ADDR_W-1:0]  addr;
        logic [TEXEL_W-1:0] value;
    } op_t;

    // Front to queue push
    typedef struct packed {
        logic valid;
        op_t  op;
    } push_t;

endpackage

// ===== sv/rotozoom_texel_fetch_core.sv =====
// Top level of the rotozoom texel fetch core.
// Affine texture mapper: texel writes, frame starts, line starts and pixel ticks
// arrive as words on the s_ channel, one per cycle when the op queue has room.
// Pixel ticks each give one texel byte on the m_ channel, read through the op
// queue into the registered output; other words give nothing. Sustained rate
// is one word per cycle while the output is free, set by the single port of the
// 32K x 8 texel store, which serves one write or one read a cycle. A four-deep
// op queue separates coordinate stepping from store access, so while the output
// is held the input keeps flowing until four store accesses wait behind the held
// pixel word. Texels must be written before they are read. Configuration
// writes are always accepted and must only be made while the core is idle.
module rotozoom_texel_fetch_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtf_pkg::COORD_W-1:0]    cfg_data,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [14:0] texel_addr, [22:15] texel_value, [27:23] slice_select, [31:28] zero
    input  logic [rtf_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [rtf_pkg::REQ_W-1:0]      s_tuser,
    // Pixel stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] pixel_value
    output logic [rtf_pkg::M_DATA_W-1:0]   m_tdata
);
    import rtf_pkg::*;

    push_t push;
    op_t   head;
    logic  q_full, q_empty, pop, in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;

    rtf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_fire      (in_fire),
        .req_type     (s_tuser),
        .texel_addr   (s_tdata[ADDR_W-1:0]),
        .texel_value  (s_tdata[ADDR_W +: TEXEL_W]),
        .slice_select (s_tdata[ADDR_W+TEXEL_W +: SLICE_BITS]),
        .push         (push)
    );

    rtf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .empty   (q_empty),
        .pop     (pop),
        .head    (head)
    );

    rtf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/rtf_front.sv =====
// Front end: configuration registers, coordinate stepping and op generation.
module rtf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [rtf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtf_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          in_fire,
    input  logic [rtf_pkg::REQ_W-1:0]     req_type,
    input  logic [rtf_pkg::ADDR_W-1:0]    texel_addr,
    input  logic [rtf_pkg::TEXEL_W-1:0]   texel_value,
    input  logic [rtf_pkg::SLICE_BITS-1:0] slice_select,
    output rtf_pkg::push_t                push
);
    import rtf_pkg::*;

    logic [COORD_W-1:0]    step_x_reg, step_y_reg, origin_x_reg, origin_y_reg;
    logic [COORD_W-1:0]    line_x_reg, line_x_next;
    logic [COORD_W-1:0]    line_y_reg, line_y_next;
    logic [COORD_W-1:0]    pix_x_reg, pix_x_next;
    logic [PY_W-1:0]       pix_y_reg, pix_y_next;
    logic [SLICE_BITS-1:0] slice_reg, slice_next;
    logic [COORD_W-1:0]    pix_x_step;
    logic [PY_W-1:0]       pix_y_step;
    logic [GRID_BITS-1:0]  col, row;

    // Stepped pixel coordinates for a pixel tick
    assign pix_x_step = pix_x_reg + step_x_reg;
    assign pix_y_step = pix_y_reg + step_y_reg[COORD_W-1:Y_DROP_BITS];
    assign col        = pix_x_step[X_FRAC_BITS +: GRID_BITS];
    assign row        = pix_y_step[ROW_LSB +: GRID_BITS];

    // Request decode
    always_comb begin
        line_x_next = line_x_reg;
        line_y_next = line_y_reg;
        pix_x_next  = pix_x_reg;
        pix_y_next  = pix_y_reg;
        slice_next  = slice_reg;
        push.valid     = 1'b0;
        push.op.rd     = 1'b0;
        push.op.addr   = texel_addr;
        push.op.value  = texel_value;
        if (in_fire) begin
            unique case (req_type)
                REQ_WRITE: begin
                    push.valid = 1'b1;
                end
                REQ_FRAME: begin
                    line_x_next = origin_x_reg;
                    line_y_next = origin_y_reg;
                end
                REQ_LINE: begin
                    slice_next  = slice_select;
                    pix_x_next  = line_x_reg;
                    pix_y_next  = line_y_reg[COORD_W-1:Y_DROP_BITS];
                    line_x_next = line_x_reg + step_y_reg;
                    line_y_next = line_y_reg - step_x_reg;
                end
                REQ_PIXEL: begin
                    pix_x_next   = pix_x_step;
                    pix_y_next   = pix_y_step;
                    push.valid   = 1'b1;
                    push.op.rd   = 1'b1;
                    push.op.addr = {row, slice_reg, col};
                end
                default: ;
            endcase
        end
    end

    // State and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            line_x_reg   <= '0;
            line_y_reg   <= '0;
            pix_x_reg    <= '0;
            pix_y_reg    <= '0;
            slice_reg    <= '0;
        end else begin
            line_x_reg <= line_x_next;
            line_y_reg <= line_y_next;
            pix_x_reg  <= pix_x_next;
            pix_y_reg  <= pix_y_next;
            slice_reg  <= slice_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_STEP_X:   step_x_reg   <= cfg_data;
                    REG_STEP_Y:   step_y_reg   <= cfg_data;
                    REG_ORIGIN_X: origin_x_reg <= cfg_data;
                    REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/rtf_queue.sv =====
// Short op queue between the front end and the texel store.
module rtf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  rtf_pkg::push_t push,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output rtf_pkg::op_t   head
);
    import rtf_pkg::*;

    op_t                slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) count_next = count_reg + 1'b1;
        if (!push.valid && pop) count_next = count_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push.valid) slot[wr_ptr_reg] <= push.op;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)        rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("op queue overfilled");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("op queue popped while empty");
    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("op queue fill level lost a word");
`endif

endmodule

// ===== sv/rtf_back.sv =====
// Back end: texel store and registered pixel output.
module rtf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  rtf_pkg::op_t                head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rtf_pkg::M_DATA_W-1:0] m_tdata
);
    import rtf_pkg::*;

    logic [TEXEL_W-1:0] mem [MEM_DEPTH];
    logic [TEXEL_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    // Writes always drain; reads wait for a free output register
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = !q_empty && (!head.rd || out_free);

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (pop && head.rd) out_valid_next = 1'b1;
    end

    // Texel store, one access per cycle
    always_ff @(posedge aclk) begin
        if (pop && !head.rd) mem[head.addr] <= head.value;
        if (pop && head.rd)  rd_data_reg    <= mem[head.addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else          out_valid_reg <= out_valid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rd_data_reg;

`ifndef SYNTHESIS
    a_read_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.rd) |-> out_free)
        else $error("texel read issued over a held pixel word");
`endif

endmodule
